// ===== hw/rtl/cfr_pkg.sv =====
// Shared types and constants for the COBS frame receiver.
// No dependencies; every other file in hw/rtl imports this package.
`timescale 1ns / 1ps

package cfr_pkg;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic [31:0] now_ms;
  } cfr_in_t;

  typedef struct packed {
    logic       status;
    logic [7:0] frame_type;
    logic [5:0] frame_length;
    logic [7:0] payload_byte;
    logic       last;
  } cfr_out_t;

  // Frame boundary events from the intake buffer
  typedef struct packed {
    logic frame_end;   // delimiter closes a collected, clean frame
    logic frame_drop;  // delimiter closes a frame marked for discard
  } cfr_evt_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEC,
    ST_CHECK,
    ST_ERR,
    ST_ZLEN,
    ST_PLD_RD,
    ST_PLD_OUT
  } cfr_state_t;

  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;

  localparam logic [CFG_AW-1:0] CFG_FRAME_TIMEOUT    = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_PAYLOAD_CAPACITY = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_REQUEST_TYPE     = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_RESPONSE_TYPE    = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_DIAGNOSTIC_TYPE  = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_REQUEST_LEN      = 3'd5;
  localparam logic [CFG_AW-1:0] CFG_REPORT_LEN       = 3'd6;

  localparam logic [31:0] RST_FRAME_TIMEOUT    = 32'd1000;
  localparam logic [5:0]  RST_PAYLOAD_CAPACITY = 6'd32;
  localparam logic [7:0]  RST_REQUEST_TYPE     = 8'd1;
  localparam logic [7:0]  RST_RESPONSE_TYPE    = 8'd2;
  localparam logic [7:0]  RST_DIAGNOSTIC_TYPE  = 8'd3;
  localparam logic [5:0]  RST_REQUEST_LEN      = 6'd32;
  localparam logic [5:0]  RST_REPORT_LEN       = 6'd16;

  localparam logic [7:0] COBS_MAX_CODE = 8'd255;
  localparam logic [7:0] DIAG_LEN      = 8'd1;
  localparam logic       STATUS_OK     = 1'b0;
  localparam logic       STATUS_ERR    = 1'b1;

endpackage

// ===== hw/rtl/cfr_enc_buffer.sv =====
// Intake side of the COBS frame receiver: frame age, overflow and discard
// tracking, plus the encoded byte memory. Depends on cfr_pkg.
`timescale 1ns / 1ps

module cfr_enc_buffer
  import cfr_pkg::*;
#(
  parameter int unsigned ENCODED_DEPTH = 64,
  localparam int unsigned EAW = $clog2(ENCODED_DEPTH),
  localparam int unsigned FW  = $clog2(ENCODED_DEPTH + 1)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_fire,
  input  cfr_in_t        in_data,
  input  logic [31:0]    frame_timeout,
  input  logic [EAW-1:0] rd_addr,
  output logic [7:0]     rd_data,
  output cfr_evt_t       evt,
  output logic [FW-1:0]  fill_count
);

  logic [7:0]    enc_mem [ENCODED_DEPTH];
  logic [7:0]    rd_data_r;
  logic [FW-1:0] fill_r, fill_nxt;
  logic          discard_r, discard_nxt;
  logic [31:0]   start_r, start_nxt;
  logic [31:0]   age;
  logic          expired;
  logic          drop_now;
  logic          wr_en;

  always_comb begin
    age         = in_data.now_ms - start_r;
    expired     = (fill_r != '0) && (age >= frame_timeout);
    drop_now    = discard_r || expired;
    fill_nxt    = fill_r;
    discard_nxt = discard_r;
    start_nxt   = start_r;
    wr_en       = 1'b0;
    evt         = '0;
    if (in_fire) begin
      if (in_data.rx_byte != 8'd0) begin
        if ((fill_r == '0) && !drop_now) begin
          start_nxt = in_data.now_ms;
        end
        if (drop_now) begin
          discard_nxt = 1'b1;
        end else if (fill_r >= FW'(ENCODED_DEPTH)) begin
          // overflow: drop the byte and the rest of the frame
          discard_nxt = 1'b1;
        end else begin
          wr_en    = 1'b1;
          fill_nxt = fill_r + FW'(1);
        end
      end else begin
        fill_nxt       = '0;
        discard_nxt    = 1'b0;
        evt.frame_drop = drop_now;
        evt.frame_end  = !drop_now && (fill_r != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      discard_r <= 1'b0;
      start_r   <= '0;
    end else begin
      fill_r    <= fill_nxt;
      discard_r <= discard_nxt;
      start_r   <= start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      enc_mem[fill_r[EAW-1:0]] <= in_data.rx_byte;
    end
    rd_data_r <= enc_mem[rd_addr];
  end

  assign rd_data    = rd_data_r;
  assign fill_count = fill_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(ENCODED_DEPTH))
    else $error("fill count beyond buffer depth");

  a_delim_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_data.rx_byte == 8'd0) |=> (fill_r == '0) && !discard_r)
    else $error("delimiter did not clear frame state");

endmodule

// ===== hw/rtl/cobs_frame_receiver_core.sv =====
// COBS frame receiver: one link byte per cycle in while idle; a delimiter is followed by
// a walk of the encoded memory (one read a cycle), a header check state, then a read
// state and an output state per payload byte through the decoded memory read port, plus any
// output stall. Input is held off from delimiter until the last result is registered.
// Reset clears config to defaults and frame state; memories are not cleared.
`timescale 1ns / 1ps

module cobs_frame_receiver_core
  import cfr_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD   = 32,
  parameter int unsigned ENCODED_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cfr_in_t           in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cfr_out_t          out_data,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  localparam int unsigned DEC_DEPTH = MAX_PAYLOAD + 2;
  localparam int unsigned DAW       = $clog2(DEC_DEPTH);
  localparam int unsigned NW        = $clog2(DEC_DEPTH + 1);
  localparam int unsigned EAW       = $clog2(ENCODED_DEPTH);
  localparam int unsigned FW        = $clog2(ENCODED_DEPTH + 1);

  // Configuration
  logic [31:0] frame_timeout_r;
  logic [5:0]  payload_capacity_r;
  logic [7:0]  request_type_r;
  logic [7:0]  response_type_r;
  logic [7:0]  diagnostic_type_r;
  logic [5:0]  request_len_r;
  logic [5:0]  report_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_timeout_r    <= RST_FRAME_TIMEOUT;
      payload_capacity_r <= RST_PAYLOAD_CAPACITY;
      request_type_r     <= RST_REQUEST_TYPE;
      response_type_r    <= RST_RESPONSE_TYPE;
      diagnostic_type_r  <= RST_DIAGNOSTIC_TYPE;
      request_len_r      <= RST_REQUEST_LEN;
      report_len_r       <= RST_REPORT_LEN;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_FRAME_TIMEOUT:    frame_timeout_r    <= cfg_wdata;
        CFG_PAYLOAD_CAPACITY: payload_capacity_r <= cfg_wdata[5:0];
        CFG_REQUEST_TYPE:     request_type_r     <= cfg_wdata[7:0];
        CFG_RESPONSE_TYPE:    response_type_r    <= cfg_wdata[7:0];
        CFG_DIAGNOSTIC_TYPE:  diagnostic_type_r  <= cfg_wdata[7:0];
        CFG_REQUEST_LEN:      request_len_r      <= cfg_wdata[5:0];
        CFG_REPORT_LEN:       report_len_r       <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  // Intake and encoded memory
  cfr_evt_t       evt;
  logic [FW-1:0]  fill_count;
  logic [EAW-1:0] enc_raddr;
  logic [7:0]     enc_q;
  logic           in_fire;

  cfr_state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  cfr_enc_buffer #(
    .ENCODED_DEPTH(ENCODED_DEPTH)
  ) u_enc_buffer (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_fire),
    .in_data      (in_data),
    .frame_timeout(frame_timeout_r),
    .rd_addr      (enc_raddr),
    .rd_data      (enc_q),
    .evt          (evt),
    .fill_count   (fill_count)
  );

  // Decode and emit datapath
  logic [FW-1:0] used_r, used_nxt;
  logic [FW-1:0] i_r, i_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [NW-1:0] k_r, k_nxt;
  logic [7:0]    cnt_r, cnt_nxt;
  logic [7:0]    prev_code_r, prev_code_nxt;
  logic          first_r, first_nxt;
  logic [7:0]    typ_r, typ_nxt;
  logic [7:0]    len_r, len_nxt;
  logic          out_valid_r, out_valid_nxt;
  cfr_out_t      out_data_r, out_data_nxt;

  logic [7:0]    dec_mem [DEC_DEPTH];
  logic [7:0]    dec_q;
  logic          dec_we;
  logic [7:0]    dec_wdata;
  logic          dec_re;
  logic [DAW-1:0] dec_raddr;

  logic [6:0]    req_clamp;
  logic [NW-1:0] bound;
  logic [FW-1:0] rem;
  logic          at_end;
  logic          dec_err;
  logic          dec_done;
  logic          type_match;
  logic          hdr_ok;
  logic          slot_free;
  logic          pld_last;

  assign req_clamp = ({1'b0, request_len_r} > 7'(MAX_PAYLOAD)) ? 7'(MAX_PAYLOAD)
                                                                : {1'b0, request_len_r};
  assign bound     = NW'(req_clamp) + NW'(2);
  assign slot_free = !out_valid_r || out_ready;
  assign pld_last  = ((8'(k_r) + 8'd1) == len_r);

  assign type_match = ((typ_r == request_type_r)    && (len_r == {2'b00, request_len_r})) ||
                      ((typ_r == response_type_r)   && (len_r == {2'b00, report_len_r}))  ||
                      ((typ_r == diagnostic_type_r) && (len_r == DIAG_LEN));
  assign hdr_ok = (n_r >= NW'(2)) &&
                  ({1'b0, len_r} == (9'(n_r) - 9'd2)) &&
                  ({2'b00, payload_capacity_r} >= len_r) &&
                  type_match;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (evt.frame_drop) begin
          state_nxt = ST_ERR;
        end else if (evt.frame_end) begin
          state_nxt = ST_DEC;
        end
      end
      ST_DEC: begin
        if (dec_err) begin
          state_nxt = ST_ERR;
        end else if (dec_done) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!hdr_ok) begin
          state_nxt = ST_ERR;
        end else if (len_r == 8'd0) begin
          state_nxt = ST_ZLEN;
        end else begin
          state_nxt = ST_PLD_RD;
        end
      end
      ST_ERR, ST_ZLEN: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PLD_RD: state_nxt = ST_PLD_OUT;
      ST_PLD_OUT: begin
        if (slot_free) begin
          state_nxt = pld_last ? ST_IDLE : ST_PLD_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    used_nxt      = used_r;
    i_nxt         = i_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    cnt_nxt       = cnt_r;
    prev_code_nxt = prev_code_r;
    first_nxt     = first_r;
    typ_nxt       = typ_r;
    len_nxt       = len_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    dec_we        = 1'b0;
    dec_wdata     = 8'd0;
    dec_err       = 1'b0;
    dec_done      = 1'b0;
    rem           = used_r - i_r - FW'(1);
    at_end        = ((i_r + FW'(1)) == used_r);
    dec_re        = (state_r == ST_PLD_RD);
    dec_raddr     = DAW'(k_r + NW'(2));
    enc_raddr     = '0;

    case (state_r)
      ST_IDLE: begin
        if (evt.frame_end) begin
          used_nxt  = fill_count;
          i_nxt     = '0;
          n_nxt     = '0;
          cnt_nxt   = 8'd0;
          first_nxt = 1'b1;
        end
      end
      ST_DEC: begin
        // enc_q holds the byte at i_r; fetch the next one
        i_nxt     = i_r + FW'(1);
        enc_raddr = i_nxt[EAW-1:0];
        if (cnt_r == 8'd0) begin
          // code byte: first close the previous group with its zero, unless that code was 255
          if (!first_r && (prev_code_r != COBS_MAX_CODE)) begin
            if (n_r >= bound) begin
              dec_err = 1'b1;
            end else begin
              dec_we    = 1'b1;
              dec_wdata = 8'd0;
            end
          end
          if ((enc_q == 8'd0) || (10'(enc_q - 8'd1) > 10'(rem))) begin
            dec_err = 1'b1;
          end
          cnt_nxt       = enc_q - 8'd1;
          prev_code_nxt = enc_q;
          first_nxt     = 1'b0;
        end else begin
          if (n_r >= bound) begin
            dec_err = 1'b1;
          end else begin
            dec_we    = 1'b1;
            dec_wdata = enc_q;
          end
          cnt_nxt = cnt_r - 8'd1;
        end
        if (dec_we) begin
          n_nxt = n_r + NW'(1);
          if (n_r == NW'(0)) begin
            typ_nxt = dec_wdata;
          end
          if (n_r == NW'(1)) begin
            len_nxt = dec_wdata;
          end
        end
        dec_done = at_end && !dec_err;
      end
      ST_CHECK: begin
        k_nxt = '0;
      end
      ST_ERR: begin
        if (slot_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.status       = STATUS_ERR;
          out_data_nxt.frame_type   = 8'd0;
          out_data_nxt.frame_length = 6'd0;
          out_data_nxt.payload_byte = 8'd0;
          out_data_nxt.last         = 1'b1;
        end
      end
      ST_ZLEN: begin
        if (slot_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.status       = STATUS_OK;
          out_data_nxt.frame_type   = typ_r;
          out_data_nxt.frame_length = 6'd0;
          out_data_nxt.payload_byte = 8'd0;
          out_data_nxt.last         = 1'b1;
        end
      end
      ST_PLD_OUT: begin
        if (slot_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.status       = STATUS_OK;
          out_data_nxt.frame_type   = typ_r;
          out_data_nxt.frame_length = len_r[5:0];
          out_data_nxt.payload_byte = dec_q;
          out_data_nxt.last         = pld_last;
          k_nxt                     = k_r + NW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    used_r      <= used_nxt;
    i_r         <= i_nxt;
    n_r         <= n_nxt;
    k_r         <= k_nxt;
    cnt_r       <= cnt_nxt;
    prev_code_r <= prev_code_nxt;
    first_r     <= first_nxt;
    typ_r       <= typ_nxt;
    len_r       <= len_nxt;
    out_data_r  <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (dec_we) begin
      dec_mem[n_r[DAW-1:0]] <= dec_wdata;
    end
    if (dec_re) begin
      dec_q <= dec_mem[dec_raddr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_dec_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DEC) |-> (n_r <= bound))
    else $error("decoded size past bound");

  a_dec_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DEC) |-> (i_r < used_r))
    else $error("decode walk past end of frame");

  a_pld_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PLD_OUT) |-> (8'(k_r) < len_r))
    else $error("payload index past frame length");

  a_err_path: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DEC) && dec_err |=> (state_r == ST_ERR))
    else $error("decode error did not lead to error transfer");

endmodule

// ===== dv/cobs_frame_receiver_core_test.sv =====
// Self-checking bench for cobs_frame_receiver_core: random COBS link traffic in,
// decoded payload bytes and reject results checked against an in-bench frame model.
// Depends on cfr_pkg and the core RTL only.
`timescale 1ns / 1ps

module cobs_frame_receiver_core_test;
  import cfr_pkg::*;

  localparam int LINK_DEPTH = 64;
  localparam int PLD_MAX    = 32;

  typedef logic [7:0] octet_q_t[$];

  // Tracks the receiver's frame state and the decoded results still owed.
  class cfr_frame_scoreboard;
    logic [31:0] frame_tmo;
    logic [5:0]  capacity;
    logic [7:0]  req_type;
    logic [7:0]  rsp_type;
    logic [7:0]  diag_type;
    logic [5:0]  req_len;
    logic [5:0]  rpt_len;

    logic [7:0]  link_buf[LINK_DEPTH];
    int          fill;
    bit          discarding;
    logic [31:0] frame_start;
    logic [7:0]  plain[PLD_MAX + 2];

    cfr_out_t    results_due[$];
    int          errors;

    function new();
      frame_tmo   = RST_FRAME_TIMEOUT;
      capacity    = RST_PAYLOAD_CAPACITY;
      req_type    = RST_REQUEST_TYPE;
      rsp_type    = RST_RESPONSE_TYPE;
      diag_type   = RST_DIAGNOSTIC_TYPE;
      req_len     = RST_REQUEST_LEN;
      rpt_len     = RST_REPORT_LEN;
      fill        = 0;
      discarding  = 1'b0;
      frame_start = '0;
      errors      = 0;
    endfunction

    function void set_register(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
      case (idx)
        CFG_FRAME_TIMEOUT:    frame_tmo  = val;
        CFG_PAYLOAD_CAPACITY: capacity   = val[5:0];
        CFG_REQUEST_TYPE:     req_type   = val[7:0];
        CFG_RESPONSE_TYPE:    rsp_type   = val[7:0];
        CFG_DIAGNOSTIC_TYPE:  diag_type  = val[7:0];
        CFG_REQUEST_LEN:      req_len    = val[5:0];
        CFG_REPORT_LEN:       rpt_len    = val[5:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return results_due.size();
    endfunction

    function void owe_reject();
      results_due.push_back('{status: STATUS_ERR, frame_type: 8'h00, frame_length: 6'd0,
                              payload_byte: 8'h00, last: 1'b1});
    endfunction

    // Decoded size, or -1 when the code bytes are malformed or overrun the bound.
    function int unpack_frame(int used);
      int bound, i, n, code, j;
      bound = (int'(req_len) > PLD_MAX) ? PLD_MAX : int'(req_len);
      bound += 2;
      i = 0;
      n = 0;
      while (i < used) begin
        code = int'(link_buf[i]);
        i++;
        if (code == 0 || code - 1 > used - i) return -1;
        for (j = 1; j < code; j++) begin
          if (n >= bound) return -1;
          plain[n] = link_buf[i];
          n++;
          i++;
        end
        if (code != int'(COBS_MAX_CODE) && i < used) begin
          if (n >= bound) return -1;
          plain[n] = 8'h00;
          n++;
        end
      end
      return n;
    endfunction

    function void close_frame();
      int         used, n, len, k;
      logic [7:0] typ;
      bit         ok;
      used = fill;
      fill = 0;
      if (discarding) begin
        discarding = 1'b0;
        owe_reject();
        return;
      end
      if (used == 0) return;
      n = unpack_frame(used);
      if (n < 2) begin
        owe_reject();
        return;
      end
      typ = plain[0];
      len = int'(plain[1]);
      if (len != n - 2 || int'(capacity) < len) begin
        owe_reject();
        return;
      end
      ok = (typ == req_type && len == int'(req_len)) ||
           (typ == rsp_type && len == int'(rpt_len)) ||
           (typ == diag_type && len == int'(DIAG_LEN));
      if (!ok) begin
        owe_reject();
        return;
      end
      if (len == 0) begin
        results_due.push_back('{status: STATUS_OK, frame_type: typ, frame_length: 6'd0,
                                payload_byte: 8'h00, last: 1'b1});
        return;
      end
      for (k = 0; k < len; k++)
        results_due.push_back('{status: STATUS_OK, frame_type: typ, frame_length: 6'(len),
                                payload_byte: plain[k + 2], last: (k == len - 1)});
    endfunction

    function void note_link_byte(cfr_in_t item);
      logic [31:0] age;
      age = item.now_ms - frame_start;
      // expiry is judged before the byte itself is looked at
      if (fill != 0 && age >= frame_tmo) discarding = 1'b1;
      if (item.rx_byte == 8'h00) begin
        close_frame();
        return;
      end
      if (fill == 0 && !discarding) frame_start = item.now_ms;
      if (discarding) return;
      if (fill >= LINK_DEPTH) begin
        discarding = 1'b1;
        return;
      end
      link_buf[fill] = item.rx_byte;
      fill++;
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(cfr_out_t got);
      cfr_out_t want;
      if (results_due.size() == 0) begin
        errors++;
        $display("%0t: result with nothing due, expected none, actual %h", $time, got);
        return;
      end
      want = results_due.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("frame_type", want.frame_type, got.frame_type);
      compare_field("frame_length", want.frame_length, got.frame_length);
      compare_field("payload_byte", want.payload_byte, got.payload_byte);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  cfr_in_t           in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  cfr_out_t          out_data;
  logic              cfg_we    = 1'b0;
  logic [CFG_AW-1:0] cfg_addr  = CFG_FRAME_TIMEOUT;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  cfr_frame_scoreboard ledger = new();
  int                  sent = 0;
  logic [31:0]         link_ms = '0;
  int                  step_max = 2;

  cobs_frame_receiver_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("cobs_frame_receiver_core_test: errors");
    $finish;
  end

  function automatic octet_q_t cobs_pack(octet_q_t raw);
    octet_q_t enc;
    int       head, run;
    enc.push_back(8'h00);
    head = 0;
    run  = 1;
    foreach (raw[k]) begin
      if (raw[k] == 8'h00) begin
        enc[head] = 8'(run);
        head = enc.size();
        enc.push_back(8'h00);
        run = 1;
      end else begin
        enc.push_back(raw[k]);
        run++;
        if (run == int'(COBS_MAX_CODE)) begin
          enc[head] = COBS_MAX_CODE;
          head = enc.size();
          enc.push_back(8'h00);
          run = 1;
        end
      end
    end
    enc[head] = 8'(run);
    return enc;
  endfunction

  function automatic logic [7:0] payload_octet();
    return ($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
  endfunction

  task automatic push_link_byte(input logic [7:0] b, input logic [31:0] t);
    int      gap;
    cfr_in_t item;
    item = '{rx_byte: b, now_ms: t};
    gap = (sent % 40 < 10) ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    ledger.note_link_byte(item);
    sent++;
  endtask

  // Send the code bytes and the delimiter; optionally jump the clock at one byte.
  task automatic send_encoded(input octet_q_t enc, input int late_at,
                              input logic [31:0] late_by);
    int k;
    for (k = 0; k <= enc.size(); k++) begin
      if (k == late_at)
        link_ms += late_by;
      else if (k > 0 && step_max > 0 && $urandom_range(0, 1) == 1)
        link_ms += 32'($urandom_range(1, step_max));
      push_link_byte((k < enc.size()) ? enc[k] : 8'h00, link_ms);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    ledger.set_register(idx, val);
  endtask

  task automatic program_all(input logic [31:0] tmo, input logic [5:0] cap,
                             input logic [7:0] rqt, input logic [7:0] rst,
                             input logic [7:0] dgt, input logic [5:0] rql,
                             input logic [5:0] rpl);
    settle();
    write_reg(CFG_FRAME_TIMEOUT, tmo);
    write_reg(CFG_PAYLOAD_CAPACITY, 32'(cap));
    write_reg(CFG_REQUEST_TYPE, 32'(rqt));
    write_reg(CFG_RESPONSE_TYPE, 32'(rst));
    write_reg(CFG_DIAGNOSTIC_TYPE, 32'(dgt));
    write_reg(CFG_REQUEST_LEN, 32'(rql));
    write_reg(CFG_REPORT_LEN, 32'(rpl));
    cfg_we <= 1'b0;
  endtask

  task automatic send_random_frame();
    octet_q_t    raw, enc;
    int          pick, len, body, late_at, k, m;
    logic [31:0] late_by;
    logic [7:0]  typ;
    late_at = -1;
    late_by = '0;
    m       = 0;
    if ($urandom_range(0, 3) == 0) link_ms = $urandom();
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      // frame for one of the configured pairs, corrupted in one of four ways when pick >= 45
      case ($urandom_range(0, 2))
        0: begin
          typ = ledger.req_type;
          len = int'(ledger.req_len);
        end
        1: begin
          typ = ledger.rsp_type;
          len = int'(ledger.rpt_len);
        end
        default: begin
          typ = ledger.diag_type;
          len = int'(DIAG_LEN);
        end
      endcase
      raw.push_back(typ);
      raw.push_back(8'(len));
      body = (len > PLD_MAX + 4) ? PLD_MAX + 4 : len;
      for (k = 0; k < body; k++) raw.push_back(payload_octet());
      if (pick >= 45) m = $urandom_range(0, 3);
      if (pick >= 45 && m == 0) raw[1] = raw[1] + 8'd1;
      enc = cobs_pack(raw);
      if (pick >= 45) begin
        case (m)
          1: enc[$urandom_range(0, enc.size() - 1)] = 8'($urandom_range(1, 255));
          2: if (enc.size() > 1) void'(enc.pop_back());
          3: begin
            late_at = $urandom_range(1, enc.size());
            late_by = ledger.frame_tmo + 32'($urandom_range(0, 2)) - 32'd1;
          end
          default: ;
        endcase
      end
    end else if (pick < 75) begin
      case ($urandom_range(0, 3))
        0: typ = ledger.req_type;
        1: typ = ledger.rsp_type;
        2: typ = ledger.diag_type;
        default: typ = 8'($urandom_range(0, 255));
      endcase
      len = $urandom_range(0, PLD_MAX + 2);
      raw.push_back(typ);
      raw.push_back(8'(len));
      for (k = 0; k < len; k++) raw.push_back(payload_octet());
      enc = cobs_pack(raw);
    end else if (pick < 85) begin
      len = $urandom_range(1, 10);
      for (k = 0; k < len; k++) enc.push_back(8'($urandom_range(1, 255)));
    end else if (pick < 90) begin
      // empty frame: the delimiter alone
    end else if (pick < 95) begin
      // fill the link buffer exactly, or run past it
      len = (pick < 93) ? LINK_DEPTH + $urandom_range(1, 3) : LINK_DEPTH;
      for (k = 0; k < len; k++) enc.push_back(8'($urandom_range(1, 255)));
    end else begin
      len = $urandom_range(2, 8);
      for (k = 0; k < len; k++) enc.push_back(8'($urandom_range(0, 255)));
    end
    send_encoded(enc, late_at, late_by);
  endtask

  task automatic run_traffic(input int budget);
    int first;
    first = sent;
    while (sent - first < budget) send_random_frame();
  endtask

  task automatic send_raw_frame(input octet_q_t raw);
    send_encoded(cobs_pack(raw), -1, '0);
  endtask

  // Result side: random back-pressure, one long hold early in the run.
  initial begin : result_sink
    int pause;
    int taken;
    taken = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (taken == 12)
        pause = 400;
      else if (taken % 32 < 8)
        pause = 0;
      else
        pause = $urandom_range(0, 8);
      if (pause > 0) begin
        out_ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      ledger.check_result(out_data);
      taken++;
    end
  end

  initial begin : link_source
    octet_q_t enc;
    int       spin;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames at reset settings, starting just below the clock wrap.
    link_ms  = 32'hFFFF_FFFE;
    step_max = 2;
    send_raw_frame('{RST_DIAGNOSTIC_TYPE, DIAG_LEN, 8'h00});
    send_raw_frame('{RST_DIAGNOSTIC_TYPE, DIAG_LEN, 8'hFF});
    enc = {};
    send_encoded(enc, -1, '0);
    send_raw_frame('{RST_DIAGNOSTIC_TYPE, 8'd2, 8'h11});
    send_raw_frame('{RST_DIAGNOSTIC_TYPE, 8'd2, 8'h11, 8'h22});
    // code byte that runs past the end of the frame
    send_encoded('{8'h05, 8'h01}, -1, '0);
    // decodes to a single byte: no room for a header
    send_encoded('{8'h02, 8'h07}, -1, '0);
    // second byte arrives exactly one timeout after the first
    send_encoded('{8'h02, 8'h07}, 1, RST_FRAME_TIMEOUT);

    program_all(32'hFFFF_FFFF, 6'd32, 8'h00, 8'hFF, 8'h80, 6'd1, 6'd32);
    step_max = 3;
    run_traffic(35);

    // zero-length responses, oversized request bound, near-instant expiry
    program_all(32'd1, 6'd0, 8'hFF, 8'h00, 8'h7F, 6'd63, 6'd0);
    step_max = 1;
    run_traffic(30);

    program_all(32'd0, 6'd2, 8'h55, 8'hAA, 8'h55, 6'd2, 6'd2);
    step_max = 2;
    run_traffic(20);

    program_all(32'($urandom_range(50, 5000)), 6'($urandom_range(0, 32)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 6'($urandom_range(1, 32)),
                6'($urandom_range(1, 32)));
    step_max = 3;
    run_traffic(40);

    program_all(32'd1000, 6'd32, 8'd1, 8'd2, 8'd3, 6'd32, 6'd16);
    run_traffic(30);

    in_valid <= 1'b0;
    for (spin = 0; spin < 50000 && ledger.pending() != 0; spin++) @(posedge clk);
    if (ledger.pending() != 0) begin
      ledger.errors++;
      $display("%0t: %0d results never arrived", $time, ledger.pending());
    end
    repeat (200) @(posedge clk);
    if (ledger.errors == 0)
      $display("cobs_frame_receiver_core_test: clean");
    else
      $display("cobs_frame_receiver_core_test: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/cfr_pkg.sv
hw/rtl/cfr_enc_buffer.sv
hw/rtl/cobs_frame_receiver_core.sv
dv/cobs_frame_receiver_core_test.sv
